// File: rtl/core/fbv_pkg.sv
// Shared types, constants and helpers for the frustum box visibility test.
`timescale 1ns / 1ps

package fbv_pkg;

	localparam int COORD_BITS   = 16;
	localparam int MATRIX_BITS  = 16;
	localparam int LANE_BITS    = 16;
	localparam int ROW_BITS     = 4 * LANE_BITS;
	localparam int PLANE_COUNT  = 6;
	localparam int CFG_IDX_BITS = 2;
	localparam int PLANE_BITS   = MATRIX_BITS + 1;
	localparam int PROD_BITS    = PLANE_BITS + COORD_BITS;
	localparam int SUM_BITS     = PROD_BITS + 2;
	// w = 1.0 in Q11.4, applied as a shift
	localparam int W_SHIFT      = 4;
	// input stage plus two stages per plane cell
	localparam int PIPE_DEPTH   = 2 * PLANE_COUNT + 1;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_ROW0 = 2'd0,
		REG_ROW1 = 2'd1,
		REG_ROW2 = 2'd2,
		REG_ROW3 = 2'd3
	} cfg_reg_t;

	typedef logic signed [COORD_BITS-1:0]  coord_t;
	typedef logic signed [MATRIX_BITS-1:0] matrix_t;
	typedef logic signed [PLANE_BITS-1:0]  plane_coef_t;
	typedef logic [ROW_BITS-1:0]           row_t;

	typedef struct packed {
		coord_t min_x;
		coord_t min_y;
		coord_t min_z;
		coord_t max_x;
		coord_t max_y;
		coord_t max_z;
	} box_t;

	typedef struct packed {
		logic visible;
	} vis_t;

	typedef struct packed {
		plane_coef_t x;
		plane_coef_t y;
		plane_coef_t z;
		plane_coef_t w;
	} plane_t;

	// per-axis extremes of the box, order-free
	typedef struct packed {
		coord_t least;
		coord_t most;
	} span_t;

	typedef struct packed {
		span_t sx;
		span_t sy;
		span_t sz;
		logic  culled;
	} cell_data_t;

	function automatic matrix_t lane(input row_t row, input int col);
		return row[col*LANE_BITS +: MATRIX_BITS];
	endfunction

	function automatic plane_t make_plane(input row_t base_row, input row_t other_row,
			input logic minus);
		plane_coef_t coef [4];
		plane_coef_t b;
		plane_coef_t o;
		for (int i = 0; i < 4; i++) begin
			b = PLANE_BITS'(lane(base_row, i));
			o = PLANE_BITS'(lane(other_row, i));
			coef[i] = minus ? (b - o) : (b + o);
		end
		return '{x: coef[0], y: coef[1], z: coef[2], w: coef[3]};
	endfunction

	function automatic span_t make_span(input coord_t lo, input coord_t hi);
		if (lo < hi)
			return '{least: lo, most: hi};
		return '{least: hi, most: lo};
	endfunction

endpackage

// File: rtl/core/fbv_box_if.sv
// Box channel: valid/ready handshake carrying one box per beat.
`timescale 1ns / 1ps

interface fbv_box_if;
	logic          valid;
	logic          ready;
	fbv_pkg::box_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/fbv_vis_if.sv
// Result channel: valid/ready handshake carrying one visibility flag per beat.
`timescale 1ns / 1ps

interface fbv_vis_if;
	logic          valid;
	logic          ready;
	fbv_pkg::vis_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/frustum_box_visibility_test.sv
// Top level: config rows, input stage and a chain of six plane cells.
// Each box beat passes through the input stage, then both stages of every plane cell, before its result is valid.
// Throughput: one box per cycle while no result beat waits; set by the two-stage plane cells, one per plane.
// The whole chain moves together; it holds only while a result beat waits.
// Reset clears all matrix rows to zero (every box visible) and empties the chain.
`timescale 1ns / 1ps

module frustum_box_visibility_test (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [fbv_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [fbv_pkg::ROW_BITS-1:0]       cfg_data,
	fbv_box_if.sink                            box,
	fbv_vis_if.source                          result
);
	import fbv_pkg::*;

	row_t       row0_q, row1_q, row2_q, row3_q;
	row_t       rows [4];
	plane_t     planes [PLANE_COUNT];
	logic       adv;
	logic       vld_s0;
	cell_data_t data_s0;
	logic       vld_chain [PLANE_COUNT+1];
	cell_data_t data_chain [PLANE_COUNT+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0_q <= '0;
			row1_q <= '0;
			row2_q <= '0;
			row3_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ROW0: row0_q <= cfg_data;
				REG_ROW1: row1_q <= cfg_data;
				REG_ROW2: row2_q <= cfg_data;
				REG_ROW3: row3_q <= cfg_data;
				default:  row0_q <= row0_q;
			endcase
		end
	end

	assign rows[0] = row0_q;
	assign rows[1] = row1_q;
	assign rows[2] = row2_q;
	assign rows[3] = row3_q;

	// planes in order: row3+row0, row3-row0, row3+row1, ...
	for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
		assign planes[p] = make_plane(row3_q, rows[p/2], 1'(p % 2));
	end

	assign adv       = !result.valid || result.ready;
	assign box.ready = adv;

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s0.sx     <= make_span(box.data.min_x, box.data.max_x);
			data_s0.sy     <= make_span(box.data.min_y, box.data.max_y);
			data_s0.sz     <= make_span(box.data.min_z, box.data.max_z);
			data_s0.culled <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (adv) begin
			vld_s0 <= box.valid;
		end
	end

	assign vld_chain[0]  = vld_s0;
	assign data_chain[0] = data_s0;

	for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_cell
		fbv_plane_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.plane_in (planes[p]),
			.vld_in   (vld_chain[p]),
			.data_in  (data_chain[p]),
			.vld_out  (vld_chain[p+1]),
			.data_out (data_chain[p+1])
		);
	end

	assign result.valid        = vld_chain[PLANE_COUNT];
	assign result.data.visible = !data_chain[PLANE_COUNT].culled;

endmodule

// File: rtl/core/fbv_plane_cell.sv
// One plane cell: tests the box against a single plane and passes it on.
`timescale 1ns / 1ps

module fbv_plane_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  fbv_pkg::plane_t     plane_in,
	input  logic                vld_in,
	input  fbv_pkg::cell_data_t data_in,
	output logic                vld_out,
	output fbv_pkg::cell_data_t data_out
);
	import fbv_pkg::*;

	plane_t                      plane_q;
	coord_t                      pick_x, pick_y, pick_z;
	logic signed [PROD_BITS-1:0] prod_x_s1, prod_y_s1, prod_z_s1, prod_w_s1;
	logic signed [SUM_BITS-1:0]  sum;
	cell_data_t                  data_s1, data_s2;
	logic                        vld_s1, vld_s2;

	always_ff @(posedge clk) begin
		plane_q <= plane_in;
	end

	// the corner that maximizes each term: larger coordinate for a positive
	// coefficient, lesser one for a negative coefficient
	assign pick_x = plane_q.x[PLANE_BITS-1] ? data_in.sx.least : data_in.sx.most;
	assign pick_y = plane_q.y[PLANE_BITS-1] ? data_in.sy.least : data_in.sy.most;
	assign pick_z = plane_q.z[PLANE_BITS-1] ? data_in.sz.least : data_in.sz.most;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_x_s1 <= PROD_BITS'(plane_q.x) * PROD_BITS'(pick_x);
			prod_y_s1 <= PROD_BITS'(plane_q.y) * PROD_BITS'(pick_y);
			prod_z_s1 <= PROD_BITS'(plane_q.z) * PROD_BITS'(pick_z);
			prod_w_s1 <= PROD_BITS'(plane_q.w) <<< W_SHIFT;
			data_s1   <= data_in;
		end
	end

	assign sum = SUM_BITS'(prod_x_s1) + SUM_BITS'(prod_y_s1)
		+ SUM_BITS'(prod_z_s1) + SUM_BITS'(prod_w_s1);

	// all corners outside iff even the best corner is strictly negative
	always_ff @(posedge clk) begin
		if (adv) begin
			data_s2.sx     <= data_s1.sx;
			data_s2.sy     <= data_s1.sy;
			data_s2.sz     <= data_s1.sz;
			data_s2.culled <= data_s1.culled | sum[SUM_BITS-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
		end
	end

	assign vld_out  = vld_s2;
	assign data_out = data_s2;

endmodule

// File: rtl/core/fbv_checker.sv
// Port-level checks for the frustum box visibility test, bound to the top level.
`timescale 1ns / 1ps

module fbv_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);
	import fbv_pkg::*;

	localparam int CNT_BITS = $clog2(PIPE_DEPTH + 1);

	logic [CNT_BITS-1:0] inflight_q;
	logic                in_beat, out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_beat && !out_beat) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (out_beat && !in_beat) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input not ready with no result pending");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("result beat without a box in flight");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_BITS'(PIPE_DEPTH))
		else $error("more boxes in flight than pipeline stages");

endmodule

bind frustum_box_visibility_test fbv_checker u_fbv_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (box.valid),
	.in_ready  (box.ready),
	.out_valid (result.valid),
	.out_ready (result.ready)
);
